### design/midpoint_circle_rasterizer_macros.svh
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer assertion macros
// Shared property wrappers for the checker; clk and rst_n must be in scope.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_CIRCLE_RASTERIZER_MACROS_SVH
`define MIDPOINT_CIRCLE_RASTERIZER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MCR_ASSERT_SAME(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("midpoint circle rasterizer: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define MCR_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("midpoint circle rasterizer: next-cycle check failed");

`endif

### design/mcr_pkg.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer package
// Shared widths, register indexes, the request type and the bounds check.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

    localparam int COORD_BITS = 9;
    localparam int RAD_BITS   = 6;
    localparam int CFG_BITS   = 10;
    localparam int PT_BITS    = 2 * COORD_BITS;
    localparam int OFS_BITS   = RAD_BITS + 1;
    localparam int DEC_BITS   = 12;
    localparam int SUM_BITS   = COORD_BITS + 2;
    localparam int CMP_BITS   = (COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS;
    localparam int STEP_BITS  = 6;
    localparam int NUM_PTS    = 8;

    localparam logic [STEP_BITS-1:0] STEP_LAST = {STEP_BITS{1'b1}};
    localparam logic [CFG_BITS-1:0]  SIZE_RESET = CFG_BITS'(400);

    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0]      cx;
        logic [COORD_BITS-1:0]      cy;
        logic [RAD_BITS-1:0]        r;
        logic signed [DEC_BITS-1:0] d_init;
    } req_t;

    typedef struct packed {
        logic [CFG_BITS-1:0] width;
        logic [CFG_BITS-1:0] height;
    } img_cfg_t;

    function automatic logic coord_inside(input logic signed [SUM_BITS-1:0] v,
                                          input logic [CFG_BITS-1:0] limit);
        logic [CMP_BITS-1:0] lo;
        logic [CMP_BITS-1:0] lim;
        lo  = CMP_BITS'(v[COORD_BITS-1:0]);
        lim = CMP_BITS'(limit);
        return (v[SUM_BITS-1:COORD_BITS] == '0) && (lo < lim);
    endfunction

endpackage

`default_nettype wire

### design/mcr_front.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer front end
// Accepts circle items and forms the queued request with its start decision.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_front (
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [mcr_pkg::COORD_BITS-1:0] center_x,
    input  wire logic [mcr_pkg::COORD_BITS-1:0] center_y,
    input  wire logic [mcr_pkg::RAD_BITS-1:0]   radius,
    input  wire logic                          q_full,
    output logic                               q_push,
    output mcr_pkg::req_t                      q_data
);
    import mcr_pkg::*;

    always_comb
    begin
        in_stall      = q_full;
        q_push        = in_valid && !q_full;
        q_data.cx     = center_x;
        q_data.cy     = center_y;
        q_data.r      = radius;
        q_data.d_init = DEC_BITS'(3) - $signed(DEC_BITS'({radius, 1'b0}));
    end

endmodule

`default_nettype wire

### design/mcr_queue.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer request queue
// Two-entry queue that decouples the front end from the step engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire mcr_pkg::req_t push_data,
    output logic               full,
    input  wire logic          pop,
    output logic               avail,
    output mcr_pkg::req_t      head
);
    import mcr_pkg::*;

    req_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    always_comb
    begin
        full        = (count_reg == 2'd2);
        avail       = (count_reg != 2'd0);
        head        = entry_reg[rd_ptr_reg];
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### design/mcr_engine.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer step engine
// One octant per circle, one step per unstalled cycle, into the output reg.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_engine (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire mcr_pkg::img_cfg_t         cfg,
    input  wire logic                      q_avail,
    input  wire mcr_pkg::req_t             q_head,
    output logic                           q_pop,
    output logic                           out_valid,
    input  wire logic                      out_stall,
    output logic [mcr_pkg::NUM_PTS-1:0][mcr_pkg::PT_BITS-1:0] points,
    output logic [mcr_pkg::NUM_PTS-1:0]    inside_mask,
    output logic                           last_step
);
    import mcr_pkg::*;

    logic                         busy_reg;
    logic                         busy_next;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [OFS_BITS-1:0]          x_reg;
    logic [OFS_BITS-1:0]          x_next;
    logic signed [OFS_BITS:0]     y_reg;
    logic signed [OFS_BITS:0]     y_next;
    logic signed [DEC_BITS-1:0]   d_reg;
    logic signed [DEC_BITS-1:0]   d_next;
    logic [STEP_BITS-1:0]         cnt_reg;
    logic [COORD_BITS-1:0]        cx_reg;
    logic [COORD_BITS-1:0]        cy_reg;
    logic [NUM_PTS-1:0][PT_BITS-1:0] pts_reg;
    logic [NUM_PTS-1:0]           mask_reg;
    logic                         last_reg;

    logic                         step;
    logic                         done;
    logic signed [DEC_BITS-1:0]   xd;
    logic signed [DEC_BITS-1:0]   yd;
    logic signed [SUM_BITS-1:0]   cxs;
    logic signed [SUM_BITS-1:0]   cys;
    logic signed [SUM_BITS-1:0]   xs;
    logic signed [SUM_BITS-1:0]   ys;
    logic signed [SUM_BITS-1:0]   px [NUM_PTS];
    logic signed [SUM_BITS-1:0]   py [NUM_PTS];
    logic [NUM_PTS-1:0][PT_BITS-1:0] pts_cur;
    logic [NUM_PTS-1:0]           mask_cur;

    always_comb
    begin
        q_pop = !busy_reg && q_avail;
        step  = busy_reg && (!out_valid_reg || !out_stall);

        xd = $signed(DEC_BITS'(x_reg));
        yd = DEC_BITS'(y_reg);
        x_next = x_reg + OFS_BITS'(1);
        if (d_reg > 0)
        begin
            d_next = d_reg + ((xd - yd) <<< 2) + DEC_BITS'(10);
            y_next = y_reg - (OFS_BITS + 1)'(1);
        end
        else
        begin
            d_next = d_reg + (xd <<< 2) + DEC_BITS'(6);
            y_next = y_reg;
        end
        done = ($signed({1'b0, x_next}) > y_next) || (cnt_reg == STEP_LAST);

        cxs = $signed(SUM_BITS'(cx_reg));
        cys = $signed(SUM_BITS'(cy_reg));
        xs  = $signed(SUM_BITS'(x_reg));
        ys  = SUM_BITS'(y_reg);
        px[0] = cxs + xs; py[0] = cys + ys;
        px[1] = cxs + xs; py[1] = cys - ys;
        px[2] = cxs - xs; py[2] = cys - ys;
        px[3] = cxs - xs; py[3] = cys + ys;
        px[4] = cxs + ys; py[4] = cys - xs;
        px[5] = cxs + ys; py[5] = cys + xs;
        px[6] = cxs - ys; py[6] = cys - xs;
        px[7] = cxs - ys; py[7] = cys + xs;
        for (int i = 0; i < NUM_PTS; i++)
        begin
            pts_cur[i]  = {px[i][COORD_BITS-1:0], py[i][COORD_BITS-1:0]};
            mask_cur[i] = coord_inside(px[i], cfg.width) && coord_inside(py[i], cfg.height);
        end

        if (step)
        begin
            busy_next = !done;
        end
        else
        begin
            busy_next = busy_reg || q_pop;
        end

        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        out_valid   = out_valid_reg;
        points      = pts_reg;
        inside_mask = mask_reg;
        last_step   = last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            x_reg         <= '0;
            y_reg         <= '0;
            d_reg         <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
            if (q_pop)
            begin
                x_reg   <= '0;
                y_reg   <= $signed((OFS_BITS + 1)'(q_head.r));
                d_reg   <= q_head.d_init;
                cnt_reg <= '0;
            end
            else if (step)
            begin
                x_reg   <= x_next;
                y_reg   <= y_next;
                d_reg   <= d_next;
                cnt_reg <= cnt_reg + STEP_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cx_reg <= q_head.cx;
            cy_reg <= q_head.cy;
        end
        if (step)
        begin
            pts_reg  <= pts_cur;
            mask_reg <= mask_cur;
            last_reg <= done;
        end
    end

endmodule

`default_nettype wire

### design/midpoint_circle_rasterizer.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer
// Turns circle items into octant steps of eight symmetric pixels each.
// ----------------------------------------------------------------------------
// The input channel takes one circle item (center_x, center_y, radius) per
// handshake; in_stall rises while the two-entry request queue is full.
// Each circle yields one output item per midpoint step, about radius/sqrt(2)
// plus one items, the final one flagged by last_step. inside_mask marks the
// pixels that fall within the image size set through the register port.
// An accepted input item is written into the request queue, loaded by the
// step engine, and its first step is registered in the output register.
// The step engine produces one output item per cycle while out_stall is low
// and loads each circle before its first step; the step loop sets this rate.
// When out_stall is high the output register holds its item and the engine
// waits; input items keep being queued until the queue fills.
// Reset empties queue and output register and sets both image sizes to 400.
// The user must write registers only while the block is idle; not enforced.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_rasterizer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [mcr_pkg::COORD_BITS-1:0] center_x,
    input  wire logic [mcr_pkg::COORD_BITS-1:0] center_y,
    input  wire logic [mcr_pkg::RAD_BITS-1:0]   radius,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic [mcr_pkg::PT_BITS-1:0]         point_0,
    output logic [mcr_pkg::PT_BITS-1:0]         point_1,
    output logic [mcr_pkg::PT_BITS-1:0]         point_2,
    output logic [mcr_pkg::PT_BITS-1:0]         point_3,
    output logic [mcr_pkg::PT_BITS-1:0]         point_4,
    output logic [mcr_pkg::PT_BITS-1:0]         point_5,
    output logic [mcr_pkg::PT_BITS-1:0]         point_6,
    output logic [mcr_pkg::PT_BITS-1:0]         point_7,
    output logic [mcr_pkg::NUM_PTS-1:0]         inside_mask,
    output logic                                last_step,
    input  wire logic                           cfg_we,
    input  wire logic                           cfg_index,
    input  wire logic [mcr_pkg::CFG_BITS-1:0]   cfg_data
);
    import mcr_pkg::*;

    img_cfg_t cfg_reg;
    img_cfg_t cfg_next;
    logic     q_full;
    logic     q_push;
    req_t     q_data;
    logic     q_pop;
    logic     q_avail;
    req_t     q_head;
    logic [NUM_PTS-1:0][PT_BITS-1:0] points;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  cfg_next.width  = cfg_data;
                REG_HEIGHT: cfg_next.height = cfg_data;
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width  <= SIZE_RESET;
            cfg_reg.height <= SIZE_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mcr_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .center_x (center_x),
        .center_y (center_y),
        .radius   (radius),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    mcr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .avail     (q_avail),
        .head      (q_head)
    );

    mcr_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .q_avail     (q_avail),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .points      (points),
        .inside_mask (inside_mask),
        .last_step   (last_step)
    );

    assign point_0 = points[0];
    assign point_1 = points[1];
    assign point_2 = points[2];
    assign point_3 = points[3];
    assign point_4 = points[4];
    assign point_5 = points[5];
    assign point_6 = points[6];
    assign point_7 = points[7];

endmodule

`default_nettype wire

### design/midpoint_circle_rasterizer_checker.sv
// ----------------------------------------------------------------------------
// Midpoint circle rasterizer checker
// Port-level checks on the output channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midpoint_circle_rasterizer_macros.svh"

module midpoint_circle_rasterizer_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic [mcr_pkg::PT_BITS-1:0]    point_0,
    input wire logic [mcr_pkg::PT_BITS-1:0]    point_1,
    input wire logic [mcr_pkg::PT_BITS-1:0]    point_2,
    input wire logic [mcr_pkg::PT_BITS-1:0]    point_3,
    input wire logic [mcr_pkg::PT_BITS-1:0]    point_4,
    input wire logic [mcr_pkg::PT_BITS-1:0]    point_5,
    input wire logic [mcr_pkg::NUM_PTS-1:0]    inside_mask,
    input wire logic                           last_step
);
    import mcr_pkg::*;

    logic [2*PT_BITS+NUM_PTS:0] held;
    logic                       pair_a_ok;
    logic                       pair_b_ok;

    assign held      = {point_0, point_4, inside_mask, last_step};
    assign pair_a_ok = (point_0[PT_BITS-1:COORD_BITS] == point_1[PT_BITS-1:COORD_BITS])
                       && (point_2[PT_BITS-1:COORD_BITS] == point_3[PT_BITS-1:COORD_BITS]);
    assign pair_b_ok = (point_4[PT_BITS-1:COORD_BITS] == point_5[PT_BITS-1:COORD_BITS]);

    // A stalled output item holds pixels 0 and 4, its mask and its last flag.
    `MCR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(held))

    // The block comes out of reset with no output item pending.
    `MCR_ASSERT_SAME(a_reset_idle, $rose(rst_n), !out_valid)

    // Mirrored pixel pairs share a column.
    `MCR_ASSERT_SAME(a_col_pair_a, out_valid, pair_a_ok)

    `MCR_ASSERT_SAME(a_col_pair_b, out_valid, pair_b_ok)

endmodule

bind midpoint_circle_rasterizer midpoint_circle_rasterizer_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .point_0     (point_0),
    .point_1     (point_1),
    .point_2     (point_2),
    .point_3     (point_3),
    .point_4     (point_4),
    .point_5     (point_5),
    .inside_mask (inside_mask),
    .last_step   (last_step)
);

`default_nettype wire
